// File: design/lvc_pkg.sv
// Shared types and constants of the MIDI lane value codec.
package lvc_pkg;

  typedef enum logic [1:0] {
    LANE_CTRL  = 2'd0,
    LANE_BEND  = 2'd1,
    LANE_PROG  = 2'd2,
    LANE_TEMPO = 2'd3
  } lane_t;

  localparam logic KIND_DECODE = 1'b0;
  localparam logic KIND_ENCODE = 1'b1;

  localparam logic [3:0] TYPE_CTRL = 4'hB;
  localparam logic [3:0] TYPE_PROG = 4'hC;
  localparam logic [3:0] TYPE_BEND = 4'hE;

  // Widths of the tempo divider: numerator 2*60e6 + d, divisor 2*d.
  localparam int NUM_W     = 28;
  localparam int DIV_W     = 25;
  localparam int DIV_STEPS = NUM_W;

  localparam logic [NUM_W-1:0] TWO_MINUTES_US = 28'd120000000;
  localparam logic [NUM_W-1:0] BPM_MAX        = 28'd16383;
  localparam logic signed [14:0] BPM_MAX_VALUE = 15'sd16383;
  localparam logic signed [14:0] BEND_CENTRE   = 15'sd8192;

  // Everything about a request that the divider does not touch.
  typedef struct packed {
    logic               kind;
    lane_t              lane;
    logic               belongs;
    logic signed [14:0] dec_value;
    logic [3:0]         out_type;
    logic [3:0]         out_channel;
    logic [6:0]         out_first_byte;
    logic [6:0]         out_second_byte;
  } lvc_side_t;

endpackage

// File: design/lvc_front.sv
// Lane matching, clamping, byte packing and divider operand set-up.
module lvc_front (
  input  logic                    single_chunk_file,
  input  logic                    kind,
  input  logic [1:0]              lane,
  input  logic [6:0]              controller,
  input  logic [3:0]              lane_channel,
  input  logic [3:0]              event_type,
  input  logic [3:0]              event_channel,
  input  logic                    event_is_channel,
  input  logic [6:0]              event_first_byte,
  input  logic [6:0]              event_second_byte,
  input  logic [23:0]             tempo_micros,
  input  logic signed [15:0]      lane_value,
  output lvc_pkg::lvc_side_t      side,
  output logic [lvc_pkg::NUM_W-1:0] num,
  output logic [lvc_pkg::DIV_W-1:0] divisor
);
  import lvc_pkg::*;

  lane_t       lane_e;
  logic        chan_ok;
  logic        type_ok;
  logic [9:0]  bpm;
  logic [13:0] bend_code;
  logic [6:0]  val_7bit;
  logic [23:0] d;

  assign lane_e = lane_t'(lane);

  always_comb begin
    if (lane_value < 16'sd1) begin
      bpm = 10'd1;
    end else if (lane_value > 16'sd999) begin
      bpm = 10'd999;
    end else begin
      bpm = lane_value[9:0];
    end

    // Inside the range, adding the centre only flips the top bit.
    if (lane_value < -16'sd8192) begin
      bend_code = 14'd0;
    end else if (lane_value > 16'sd8191) begin
      bend_code = 14'h3FFF;
    end else begin
      bend_code = {~lane_value[13], lane_value[12:0]};
    end

    if (lane_value < 16'sd0) begin
      val_7bit = 7'd0;
    end else if (lane_value > 16'sd127) begin
      val_7bit = 7'h7F;
    end else begin
      val_7bit = lane_value[6:0];
    end
  end

  always_comb begin
    chan_ok = event_is_channel && (!single_chunk_file || (event_channel == lane_channel));
    side.kind        = kind;
    side.lane        = lane_e;
    side.out_channel = lane_channel;
    case (lane_e)
      LANE_BEND: begin
        type_ok              = (event_type == TYPE_BEND);
        side.dec_value       = $signed({1'b0, event_second_byte, event_first_byte}) - BEND_CENTRE;
        side.out_type        = TYPE_BEND;
        side.out_first_byte  = bend_code[6:0];
        side.out_second_byte = bend_code[13:7];
      end
      LANE_PROG: begin
        type_ok              = (event_type == TYPE_PROG);
        side.dec_value       = $signed({8'd0, event_first_byte});
        side.out_type        = TYPE_PROG;
        side.out_first_byte  = val_7bit;
        side.out_second_byte = 7'd0;
      end
      LANE_CTRL: begin
        type_ok              = (event_type == TYPE_CTRL) && (event_first_byte == controller);
        side.dec_value       = $signed({8'd0, event_second_byte});
        side.out_type        = TYPE_CTRL;
        side.out_first_byte  = controller;
        side.out_second_byte = val_7bit;
      end
      default: begin
        type_ok              = 1'b1;
        side.dec_value       = 15'sd0;
        side.out_type        = 4'd0;
        side.out_first_byte  = 7'd0;
        side.out_second_byte = 7'd0;
      end
    endcase
    side.belongs = (lane_e == LANE_TEMPO) ? 1'b1 : (chan_ok && type_ok);

    if (lane_e != LANE_TEMPO) begin
      d = 24'd0;
    end else if (kind == KIND_DECODE) begin
      d = tempo_micros;
    end else begin
      d = {14'd0, bpm};
    end
  end

  // Rounding half up: floor((2*60e6 + d) / (2*d)).
  assign num     = TWO_MINUTES_US + {4'd0, d};
  assign divisor = {d, 1'b0};

endmodule

// File: design/lvc_div_cell.sv
// One restoring divider cell: one quotient bit and a pipeline register.
module lvc_div_cell (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      valid_i,
  output logic                      ready_o,
  input  logic [lvc_pkg::DIV_W-1:0] rem_i,
  input  logic [lvc_pkg::NUM_W-1:0] nq_i,
  input  logic [lvc_pkg::DIV_W-1:0] div_i,
  input  lvc_pkg::lvc_side_t        side_i,
  output logic                      valid_o,
  input  logic                      ready_i,
  output logic [lvc_pkg::DIV_W-1:0] rem_o,
  output logic [lvc_pkg::NUM_W-1:0] nq_o,
  output logic [lvc_pkg::DIV_W-1:0] div_o,
  output lvc_pkg::lvc_side_t        side_o
);
  import lvc_pkg::*;

  logic [DIV_W:0]   trial;
  logic [DIV_W+1:0] diff;
  logic             borrow;
  logic [DIV_W-1:0] rem_next;
  logic [NUM_W-1:0] nq_next;

  // The numerator shifts out at the top while quotient bits shift in below.
  always_comb begin
    trial    = {rem_i, nq_i[NUM_W-1]};
    diff     = {1'b0, trial} - {2'b00, div_i};
    borrow   = diff[DIV_W+1];
    rem_next = borrow ? trial[DIV_W-1:0] : diff[DIV_W-1:0];
    nq_next  = {nq_i[NUM_W-2:0], ~borrow};
  end

  assign ready_o = !valid_o || ready_i;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_o <= 1'b0;
    end else if (ready_o) begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_o && valid_i) begin
      rem_o  <= rem_next;
      nq_o   <= nq_next;
      div_o  <= div_i;
      side_o <= side_i;
    end
  end

endmodule

// File: design/midi_lane_value_codec.sv
// Top level of the MIDI lane value codec: front logic, divider chain, output register.
// An accepted request passes through 28 divider cells and the output register to out_valid;
// throughput: one request per cycle while out_ready does not stall the chain.
// Each cell computes one quotient bit of the tempo division, so the cell count sets latency.
// A zero tempo divides by zero, gives an all-ones quotient and so saturates.
// rst (synchronous) empties every stage and clears single_chunk_file to 0.
module midi_lane_value_codec (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic               cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               kind,
  input  logic [1:0]         lane,
  input  logic [6:0]         controller,
  input  logic [3:0]         lane_channel,
  input  logic [3:0]         event_type,
  input  logic [3:0]         event_channel,
  input  logic               event_is_channel,
  input  logic [6:0]         event_first_byte,
  input  logic [6:0]         event_second_byte,
  input  logic [23:0]        tempo_micros,
  input  logic signed [15:0] lane_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               belongs,
  output logic signed [14:0] decoded_value,
  output logic [3:0]         out_type,
  output logic [3:0]         out_channel,
  output logic [6:0]         out_first_byte,
  output logic [6:0]         out_second_byte,
  output logic               out_is_tempo,
  output logic [23:0]        out_tempo_micros
);
  import lvc_pkg::*;

  logic single_chunk_file;

  logic             valid_c [0:DIV_STEPS];
  logic             ready_c [0:DIV_STEPS];
  logic [DIV_W-1:0] rem_c   [0:DIV_STEPS];
  logic [NUM_W-1:0] nq_c    [0:DIV_STEPS];
  logic [DIV_W-1:0] div_c   [0:DIV_STEPS];
  lvc_side_t        side_c  [0:DIV_STEPS];

  lvc_side_t        last_side;
  logic [NUM_W-1:0] quotient;
  logic             is_tempo;
  logic             take;

  always_ff @(posedge clk) begin
    if (rst) begin
      single_chunk_file <= 1'b0;
    end else if (cfg_write) begin
      single_chunk_file <= cfg_data;
    end
  end

  lvc_front u_front (
    .single_chunk_file (single_chunk_file),
    .kind              (kind),
    .lane              (lane),
    .controller        (controller),
    .lane_channel      (lane_channel),
    .event_type        (event_type),
    .event_channel     (event_channel),
    .event_is_channel  (event_is_channel),
    .event_first_byte  (event_first_byte),
    .event_second_byte (event_second_byte),
    .tempo_micros      (tempo_micros),
    .lane_value        (lane_value),
    .side              (side_c[0]),
    .num               (nq_c[0]),
    .divisor           (div_c[0])
  );

  assign valid_c[0] = in_valid;
  assign rem_c[0]   = '0;
  assign in_ready   = ready_c[0];

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_cell
    lvc_div_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .valid_i (valid_c[k]),
      .ready_o (ready_c[k]),
      .rem_i   (rem_c[k]),
      .nq_i    (nq_c[k]),
      .div_i   (div_c[k]),
      .side_i  (side_c[k]),
      .valid_o (valid_c[k+1]),
      .ready_i (ready_c[k+1]),
      .rem_o   (rem_c[k+1]),
      .nq_o    (nq_c[k+1]),
      .div_o   (div_c[k+1]),
      .side_o  (side_c[k+1])
    );
  end

  assign ready_c[DIV_STEPS] = !out_valid || out_ready;
  assign take      = ready_c[DIV_STEPS] && valid_c[DIV_STEPS];
  assign last_side = side_c[DIV_STEPS];
  assign quotient  = nq_c[DIV_STEPS];
  assign is_tempo  = (last_side.lane == LANE_TEMPO);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ready_c[DIV_STEPS]) begin
      out_valid <= valid_c[DIV_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      belongs          <= 1'b0;
      decoded_value    <= 15'sd0;
      out_type         <= 4'd0;
      out_channel      <= 4'd0;
      out_first_byte   <= 7'd0;
      out_second_byte  <= 7'd0;
      out_is_tempo     <= 1'b0;
      out_tempo_micros <= 24'd0;
      if (last_side.kind == KIND_DECODE) begin
        belongs <= last_side.belongs;
        if (!is_tempo) begin
          decoded_value <= last_side.dec_value;
        end else if (quotient > BPM_MAX) begin
          decoded_value <= BPM_MAX_VALUE;
        end else begin
          decoded_value <= $signed(quotient[14:0]);
        end
      end else if (is_tempo) begin
        out_is_tempo     <= 1'b1;
        out_tempo_micros <= quotient[23:0];
      end else begin
        out_type        <= last_side.out_type;
        out_channel     <= last_side.out_channel;
        out_first_byte  <= last_side.out_first_byte;
        out_second_byte <= last_side.out_second_byte;
      end
    end
  end

endmodule

// File: tb/tb_midi_lane_value_codec.sv
// Self-checking testbench for the MIDI lane value codec: directed table, then random traffic.
module tb_midi_lane_value_codec;
  timeunit 1ns;
  timeprecision 1ps;

  import lvc_pkg::*;

  localparam int CLK_PERIOD = 12;
  localparam int RESET_CYCLES = 8;
  localparam int RANDOM_PHASES = 5;
  localparam int REQUESTS_PER_PHASE = 250;
  localparam int SETTLE_CYCLES = 40;
  localparam int CYCLE_LIMIT = 500000;

  typedef struct packed {
    logic               kind;
    lane_t              lane;
    logic [6:0]         controller;
    logic [3:0]         lane_channel;
    logic [3:0]         event_type;
    logic [3:0]         event_channel;
    logic               event_is_channel;
    logic [6:0]         event_first_byte;
    logic [6:0]         event_second_byte;
    logic [23:0]        tempo_micros;
    logic signed [15:0] lane_value;
  } lane_request_t;

  typedef struct packed {
    logic               belongs;
    logic signed [14:0] decoded_value;
    logic [3:0]         out_type;
    logic [3:0]         out_channel;
    logic [6:0]         out_first_byte;
    logic [6:0]         out_second_byte;
    logic               out_is_tempo;
    logic [23:0]        out_tempo_micros;
  } lane_result_t;

  typedef struct {
    bit            mode_change;
    bit            mode;
    lane_request_t request;
    bit            typed;
    lane_result_t  want;
  } directed_row_t;

  typedef enum logic [1:0] {
    RX_FREE,
    RX_COIN,
    RX_SPARSE,
    RX_EVERY_THIRD
  } rx_pattern_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_write = 1'b0;
  logic               cfg_data = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic               kind = 1'b0;
  logic [1:0]         lane = 2'd0;
  logic [6:0]         controller = 7'd0;
  logic [3:0]         lane_channel = 4'd0;
  logic [3:0]         event_type = 4'd0;
  logic [3:0]         event_channel = 4'd0;
  logic               event_is_channel = 1'b0;
  logic [6:0]         event_first_byte = 7'd0;
  logic [6:0]         event_second_byte = 7'd0;
  logic [23:0]        tempo_micros = 24'd0;
  logic signed [15:0] lane_value = 16'sd0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic               belongs;
  logic signed [14:0] decoded_value;
  logic [3:0]         out_type;
  logic [3:0]         out_channel;
  logic [6:0]         out_first_byte;
  logic [6:0]         out_second_byte;
  logic               out_is_tempo;
  logic [23:0]        out_tempo_micros;

  lane_result_t  pending_results[$];
  directed_row_t directed_rows[$];
  logic          file_mode = 1'b0;
  int            errors = 0;
  int            cycle = 0;
  rx_pattern_t   rx_pattern = RX_FREE;
  int            rx_left = 0;

  midi_lane_value_codec uut (.*);

  initial begin
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  function automatic int clamp_to(int v, int lo, int hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  // Expected result of one request under the given file format.
  function automatic lane_result_t predict_result(lane_request_t r, logic single_chunk);
    lane_result_t      res;
    logic              hit;
    longint unsigned   q;
    int                v;
    int                b;
    res = '0;
    if (r.kind == KIND_DECODE) begin
      if (r.lane == LANE_TEMPO) begin
        res.belongs = 1'b1;
        if (r.tempo_micros == 24'd0) begin
          q = 64'd16383;
        end else begin
          q = (64'd120000000 + r.tempo_micros) / (64'd2 * r.tempo_micros);
        end
        res.decoded_value = (q > 64'd16383) ? 15'sd16383 : 15'(q);
      end else begin
        hit = r.event_is_channel && !(single_chunk && r.event_channel != r.lane_channel);
        case (r.lane)
          LANE_BEND: begin
            hit = hit && r.event_type == TYPE_BEND;
            v = {r.event_second_byte, r.event_first_byte};
            res.decoded_value = 15'(v - 8192);
          end
          LANE_PROG: begin
            hit = hit && r.event_type == TYPE_PROG;
            res.decoded_value = 15'(r.event_first_byte);
          end
          default: begin
            hit = hit && r.event_type == TYPE_CTRL && r.event_first_byte == r.controller;
            res.decoded_value = 15'(r.event_second_byte);
          end
        endcase
        res.belongs = hit;
      end
    end else begin
      v = r.lane_value;
      case (r.lane)
        LANE_TEMPO: begin
          b = clamp_to(v, 1, 999);
          q = (64'd120000000 + b) / (64'd2 * b);
          res.out_is_tempo = 1'b1;
          res.out_tempo_micros = q[23:0];
        end
        LANE_BEND: begin
          b = clamp_to(v, -8192, 8191) + 8192;
          res.out_type = TYPE_BEND;
          res.out_channel = r.lane_channel;
          res.out_first_byte = b[6:0];
          res.out_second_byte = b[13:7];
        end
        LANE_PROG: begin
          res.out_type = TYPE_PROG;
          res.out_channel = r.lane_channel;
          res.out_first_byte = 7'(clamp_to(v, 0, 127));
        end
        default: begin
          res.out_type = TYPE_CTRL;
          res.out_channel = r.lane_channel;
          res.out_first_byte = r.controller;
          res.out_second_byte = 7'(clamp_to(v, 0, 127));
        end
      endcase
    end
    return res;
  endfunction

  function automatic lane_request_t decode_request(lane_t l, logic [6:0] ctrl, logic [3:0] lch,
                                                   logic [3:0] etype, logic [3:0] ech,
                                                   logic eis, logic [6:0] b0, logic [6:0] b1,
                                                   logic [23:0] us);
    lane_request_t r;
    r = '0;
    r.kind = KIND_DECODE;
    r.lane = l;
    r.controller = ctrl;
    r.lane_channel = lch;
    r.event_type = etype;
    r.event_channel = ech;
    r.event_is_channel = eis;
    r.event_first_byte = b0;
    r.event_second_byte = b1;
    r.tempo_micros = us;
    return r;
  endfunction

  function automatic lane_request_t encode_request(lane_t l, logic [6:0] ctrl, logic [3:0] lch,
                                                   int v);
    lane_request_t r;
    r = '0;
    r.kind = KIND_ENCODE;
    r.lane = l;
    r.controller = ctrl;
    r.lane_channel = lch;
    r.lane_value = 16'(v);
    return r;
  endfunction

  function automatic lane_result_t decoded(logic b, int v);
    lane_result_t res;
    res = '0;
    res.belongs = b;
    res.decoded_value = 15'(v);
    return res;
  endfunction

  function automatic lane_result_t encoded(logic [3:0] t, logic [3:0] ch, logic [6:0] b0,
                                           logic [6:0] b1);
    lane_result_t res;
    res = '0;
    res.out_type = t;
    res.out_channel = ch;
    res.out_first_byte = b0;
    res.out_second_byte = b1;
    return res;
  endfunction

  function automatic lane_result_t tempo_event(logic [23:0] us);
    lane_result_t res;
    res = '0;
    res.out_is_tempo = 1'b1;
    res.out_tempo_micros = us;
    return res;
  endfunction

  // Mostly well-formed events aimed at the lane, with some noise and full-range values.
  function automatic lane_request_t random_request();
    lane_request_t r;
    int            pick;
    r.kind = 1'($urandom_range(0, 1));
    r.lane = lane_t'($urandom_range(0, 3));
    r.controller = 7'($urandom);
    r.lane_channel = 4'($urandom);
    r.event_type = 4'($urandom);
    r.event_channel = 4'($urandom);
    r.event_is_channel = 1'($urandom_range(0, 1));
    r.event_first_byte = 7'($urandom);
    r.event_second_byte = 7'($urandom);
    r.lane_value = 16'($urandom);
    pick = $urandom_range(0, 9);
    if (pick < 7) begin
      r.event_is_channel = 1'b1;
      if (pick < 6) r.event_channel = r.lane_channel;
      case (r.lane)
        LANE_CTRL: begin
          r.event_type = TYPE_CTRL;
          if (pick < 5) r.event_first_byte = r.controller;
        end
        LANE_BEND: r.event_type = TYPE_BEND;
        LANE_PROG: r.event_type = TYPE_PROG;
        default: ;
      endcase
    end
    case ($urandom_range(0, 4))
      0: r.tempo_micros = 24'($urandom_range(0, 8000));
      1: r.tempo_micros = 24'($urandom_range(60000, 2000000));
      2: r.tempo_micros = ($urandom_range(0, 1) == 0) ? 24'd0 : 24'hFFFFFF;
      default: r.tempo_micros = 24'($urandom);
    endcase
    case ($urandom_range(0, 5))
      0: r.lane_value = 16'($urandom_range(0, 1100));
      1: r.lane_value = 16'($urandom_range(0, 16383) - 8192);
      2: begin
        case ($urandom_range(0, 7))
          0: r.lane_value = 16'h8000;
          1: r.lane_value = 16'h7FFF;
          2: r.lane_value = 16'(-8193);
          3: r.lane_value = 16'd8192;
          4: r.lane_value = 16'hFFFF;
          5: r.lane_value = 16'd128;
          6: r.lane_value = 16'd1000;
          default: r.lane_value = 16'd0;
        endcase
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic add_row(lane_request_t r, bit typed, lane_result_t want);
    directed_row_t row;
    row.mode_change = 1'b0;
    row.mode = 1'b0;
    row.request = r;
    row.typed = typed;
    row.want = want;
    directed_rows.insert(directed_rows.size(), row);
  endtask

  task automatic add_mode(bit m);
    directed_row_t row;
    row = '{default: '0};
    row.mode_change = 1'b1;
    row.mode = m;
    directed_rows.insert(directed_rows.size(), row);
  endtask

  task automatic send_request(lane_request_t r, lane_result_t want);
    in_valid <= 1'b1;
    kind <= r.kind;
    lane <= r.lane;
    controller <= r.controller;
    lane_channel <= r.lane_channel;
    event_type <= r.event_type;
    event_channel <= r.event_channel;
    event_is_channel <= r.event_is_channel;
    event_first_byte <= r.event_first_byte;
    event_second_byte <= r.event_second_byte;
    tempo_micros <= r.tempo_micros;
    lane_value <= r.lane_value;
    do @(posedge clk); while (!in_ready);
    pending_results.insert(pending_results.size(), want);
  endtask

  task automatic wait_for_drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // The register may only change once every outstanding request has come back.
  task automatic set_file_format(bit m);
    wait_for_drain();
    cfg_write <= 1'b1;
    cfg_data <= m;
    @(posedge clk);
    cfg_write <= 1'b0;
    file_mode = m;
  endtask

  task automatic compare_field(string field, logic signed [31:0] want, logic signed [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin : result_check
    lane_result_t want;
    cycle <= cycle + 1;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("result with no request outstanding");
        errors++;
      end else begin
        want = pending_results.pop_front();
        compare_field("belongs", want.belongs, belongs);
        compare_field("decoded_value", want.decoded_value, decoded_value);
        compare_field("out_type", want.out_type, out_type);
        compare_field("out_channel", want.out_channel, out_channel);
        compare_field("out_first_byte", want.out_first_byte, out_first_byte);
        compare_field("out_second_byte", want.out_second_byte, out_second_byte);
        compare_field("out_is_tempo", want.out_is_tempo, out_is_tempo);
        compare_field("out_tempo_micros", want.out_tempo_micros, out_tempo_micros);
      end
    end
  end

  // The receiver switches between free flow, coin tosses, rare acceptance and a fixed rhythm.
  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_pattern <= rx_pattern_t'($urandom_range(0, 3));
      rx_left <= $urandom_range(20, 200);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_pattern)
      RX_FREE: out_ready <= 1'b1;
      RX_COIN: out_ready <= 1'($urandom_range(0, 1));
      RX_SPARSE: out_ready <= ($urandom_range(0, 15) == 0);
      default: out_ready <= (cycle % 3) != 0;
    endcase
  end

  initial begin
    wait (cycle >= CYCLE_LIMIT);
    $display("simulation failed");
    $finish;
  end

  initial begin : stimulus
    lane_request_t r;
    int            burst_left;
    int            gap;

    // Decode rows: tempo (zero and tiny periods saturate, and the rounding edge near saturation), then other lanes.
    add_row(decode_request(LANE_TEMPO, 0, 0, 0, 0, 0, 0, 0, 24'd0), 1, decoded(1, 16383));
    add_row(decode_request(LANE_TEMPO, 0, 0, 0, 0, 0, 0, 0, 24'd1), 1, decoded(1, 16383));
    add_row(decode_request(LANE_TEMPO, 0, 0, 0, 0, 0, 0, 0, 24'd500000), 1, decoded(1, 120));
    add_row(decode_request(LANE_TEMPO, 0, 0, 0, 0, 0, 0, 0, 24'hFFFFFF), 1, decoded(1, 4));
    add_row(decode_request(LANE_TEMPO, 0, 0, 0, 0, 0, 0, 0, 24'd3662), 0, '0);
    add_row(decode_request(LANE_TEMPO, 0, 0, 0, 0, 0, 0, 0, 24'd3663), 0, '0);
    add_row(decode_request(LANE_BEND, 0, 3, TYPE_BEND, 3, 1, 0, 0, 0), 1, decoded(1, -8192));
    add_row(decode_request(LANE_BEND, 0, 3, TYPE_BEND, 3, 1, 127, 127, 0), 1,
            decoded(1, 8191));
    add_row(decode_request(LANE_CTRL, 7, 1, TYPE_CTRL, 1, 1, 7, 100, 0), 1, decoded(1, 100));
    add_row(decode_request(LANE_CTRL, 7, 1, TYPE_CTRL, 1, 1, 8, 100, 0), 1, decoded(0, 100));
    add_row(decode_request(LANE_PROG, 0, 4, TYPE_PROG, 4, 1, 127, 0, 0), 1, decoded(1, 127));
    // A non-channel event still carries its value.
    add_row(decode_request(LANE_PROG, 0, 4, TYPE_PROG, 4, 0, 5, 0, 0), 1, decoded(0, 5));
    add_row(decode_request(LANE_BEND, 0, 2, TYPE_CTRL, 2, 1, 0, 64, 0), 1, decoded(0, 0));
    // Channels differ, which only matters for a single-chunk file.
    add_row(decode_request(LANE_PROG, 0, 2, TYPE_PROG, 9, 1, 33, 0, 0), 1, decoded(1, 33));
    add_mode(1);
    add_row(decode_request(LANE_PROG, 0, 2, TYPE_PROG, 9, 1, 33, 0, 0), 1, decoded(0, 33));
    add_row(decode_request(LANE_CTRL, 127, 15, TYPE_CTRL, 15, 1, 127, 0, 0), 1,
            decoded(1, 0));
    add_row(decode_request(LANE_TEMPO, 0, 1, 0, 6, 0, 0, 0, 24'd600000), 1, decoded(1, 100));
    add_mode(0);
    add_row(encode_request(LANE_CTRL, 127, 15, -32768), 1, encoded(TYPE_CTRL, 15, 127, 0));
    add_row(encode_request(LANE_CTRL, 0, 0, 32767), 1, encoded(TYPE_CTRL, 0, 0, 127));
    add_row(encode_request(LANE_BEND, 0, 5, -32768), 1, encoded(TYPE_BEND, 5, 0, 0));
    add_row(encode_request(LANE_BEND, 0, 5, 32767), 1, encoded(TYPE_BEND, 5, 127, 127));
    add_row(encode_request(LANE_BEND, 0, 5, 0), 1, encoded(TYPE_BEND, 5, 0, 64));
    add_row(encode_request(LANE_PROG, 0, 9, -1), 1, encoded(TYPE_PROG, 9, 0, 0));
    add_row(encode_request(LANE_PROG, 0, 9, 200), 1, encoded(TYPE_PROG, 9, 127, 0));
    // One beat per minute needs more than 24 bits and wraps.
    add_row(encode_request(LANE_TEMPO, 0, 0, 0), 1, tempo_event(24'd9668352));
    add_row(encode_request(LANE_TEMPO, 0, 0, 32767), 1, tempo_event(24'd60060));
    add_row(encode_request(LANE_TEMPO, 0, 0, 120), 0, '0);

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].mode_change) begin
        set_file_format(directed_rows[i].mode);
      end else begin
        send_request(directed_rows[i].request,
                     directed_rows[i].typed ? directed_rows[i].want
                                            : predict_result(directed_rows[i].request,
                                                             file_mode));
      end
    end

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      set_file_format(p % 2 == 0);
      burst_left = $urandom_range(1, 24);
      for (int n = 0; n < REQUESTS_PER_PHASE; n++) begin
        r = random_request();
        send_request(r, predict_result(r, file_mode));
        if (p == 1 && n == REQUESTS_PER_PHASE / 2) begin
          wait_for_drain();
        end else if (--burst_left == 0) begin
          burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 200)
                                                   : $urandom_range(1, 24);
          gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
          end
        end
      end
    end

    wait_for_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// File: sim.f
design/lvc_pkg.sv
design/lvc_front.sv
design/lvc_div_cell.sv
design/midi_lane_value_codec.sv
tb/tb_midi_lane_value_codec.sv
